// ----- hdl/srr_pkg.sv -----
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants of the sprite row rasterizer
// Item and pixel transaction layouts, the pipeline stage record between the
// fetch and shade stages, function codes and configuration register indexes.
// ----------------------------------------------------------------------------
package srr_pkg;

  // Store depths
  localparam int TILE_WORDS      = 8192;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

  // Span of the raw tile word address space (13-bit address field)
  localparam int ADDR_SPAN = 8192;

  // One sprite row: four tiles of eight pixels
  localparam int PIXELS_PER_ROW = 32;
  localparam int PIX_IDX_W      = $clog2(PIXELS_PER_ROW);
  localparam logic [PIX_IDX_W-1:0] PIX_LAST = PIX_IDX_W'(PIXELS_PER_ROW - 1);
  localparam logic [2:0] COL_LAST = 3'd7;

  // Sprite mode that hides the sprite
  localparam logic [1:0] MODE_HIDDEN = 2'd2;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_PAL_WRITE  = 2'd0,
    FUNC_TILE_WRITE = 2'd1,
    FUNC_RENDER     = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH_MINUS_ONE = 2'd0,
    CFG_SCREEN_HEIGHT   = 2'd1
  } cfg_idx_e;

  localparam logic [7:0] WIDTH_MINUS_ONE_RST = 8'd239;
  localparam logic [8:0] SCREEN_HEIGHT_RST   = 9'd160;

  // Input transaction
  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] address;
    logic [31:0] data;
    logic [15:0] attr0;
    logic [15:0] attr1;
    logic [15:0] attr2;
    logic [2:0]  sprite_row;
  } item_t;

  // Output transaction
  typedef struct packed {
    logic signed [9:0] pixel_x;
    logic [8:0]        pixel_y;
    logic [15:0]       color;
    logic              write_enable;
    logic              last;
  } pixel_t;

  // Record handed from the fetch stage to the shade stage
  typedef struct packed {
    logic              valid;
    logic signed [9:0] x;
    logic [8:0]        y;
    logic              visible;
    logic [3:0]        bank;
    logic [2:0]        col;
    logic              last;
    logic              pal_wr;
    logic [PAL_AW-1:0] pal_addr;
    logic [14:0]       pal_data;
  } stage_t;

endpackage

// ----- hdl/sprite_row_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// sprite_row_rasterizer_core: one row of a 32x8 4bpp tiled sprite
// Top level with configuration registers, fetch stage and shade stage.
// ----------------------------------------------------------------------------
// A render transaction produces 32 pixel transactions, one per cycle while
// the result channel does not stall, because the tile store is read once
// per pixel through its single read port; the next transaction is taken in
// the cycle of the last pixel read, so rows follow each other without a gap.
// A pixel reaches the result channel through the tile read register, then
// the palette read into the result register.
// The tile and palette stores start undefined and need no clearing after
// reset; the configuration port is always ready.
module sprite_row_rasterizer_core #(
  parameter int TileWords = srr_pkg::TILE_WORDS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  srr_pkg::item_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output srr_pkg::pixel_t out_item_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [8:0]      cfg_data_i
);

  logic [7:0]      width_minus_one_q;
  logic [8:0]      screen_height_q;
  logic            advance;
  srr_pkg::stage_t stage;
  logic [31:0]     tile_word;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_minus_one_q <= srr_pkg::WIDTH_MINUS_ONE_RST;
      screen_height_q   <= srr_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        srr_pkg::CFG_WIDTH_MINUS_ONE: width_minus_one_q <= cfg_data_i[7:0];
        srr_pkg::CFG_SCREEN_HEIGHT:   screen_height_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  srr_fetch #(
    .TileWords (TileWords)
  ) u_fetch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_item_i       (in_item_i),
    .screen_height_i (screen_height_q),
    .advance_i       (advance),
    .stage_o         (stage),
    .tile_word_o     (tile_word)
  );

  srr_shade u_shade (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .stage_i           (stage),
    .tile_word_i       (tile_word),
    .width_minus_one_i (width_minus_one_q),
    .advance_o         (advance),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_item_o        (out_item_o)
  );

endmodule

// ----- hdl/srr_fetch.sv -----
// ----------------------------------------------------------------------------
// srr_fetch: item intake, row sequencer and tile store
// Accepts transactions, writes tile words, and steps through the 32 pixels
// of a rendered row, reading the tile store once per pixel.
// ----------------------------------------------------------------------------
module srr_fetch #(
  parameter int TileWords = srr_pkg::TILE_WORDS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  srr_pkg::item_t  in_item_i,
  input  logic [8:0]      screen_height_i,
  input  logic            advance_i,
  output srr_pkg::stage_t stage_o,
  output logic [31:0]     tile_word_o
);

  localparam int TileAw    = $clog2(TileWords);
  localparam int WrapW     = 17;
  localparam int WrapSteps =
    $clog2((srr_pkg::ADDR_SPAN + TileWords - 1) / TileWords);

  // Reduce a raw 13-bit word address into the store depth
  function automatic logic [TileAw-1:0] wrap_addr(input logic [12:0] a);
    logic [WrapW-1:0] r;
    r = WrapW'(a);
    for (int j = WrapSteps - 1; j >= 0; j--) begin
      if (r >= (WrapW'(TileWords) << j)) begin
        r = r - (WrapW'(TileWords) << j);
      end
    end
    return r[TileAw-1:0];
  endfunction

  // Sequencer state
  logic                          active_q;
  logic [srr_pkg::PIX_IDX_W-1:0] k_q;
  logic signed [8:0]             x0_q;
  logic [8:0]                    y_q;
  logic                          visible_q;
  logic [3:0]                    bank_q;
  logic [TileAw-1:0]             tile_addr_q;

  // Stage register toward shade
  logic                          s1_valid_q;
  logic                          s1_pal_wr_q;
  srr_pkg::stage_t               s1_q;

  // Tile store
  logic [31:0]                   tile_mem [TileWords];
  logic [31:0]                   tile_rdata_q;

  logic                          accept;
  logic                          acc_pal;
  logic                          acc_tile;
  logic                          acc_render;
  logic                          issue;
  logic [8:0]                    row_y;
  logic signed [9:0]             pix_x;
  logic [TileAw:0]               tile_next_raw;
  logic [TileAw-1:0]             tile_next;

  // Accept on the last issued pixel so rows follow without a gap
  assign in_ready_o = advance_i && (!active_q || (k_q == srr_pkg::PIX_LAST));
  assign accept     = in_valid_i && in_ready_o;
  assign acc_pal    = accept && (in_item_i.func == srr_pkg::FUNC_PAL_WRITE);
  assign acc_tile   = accept && (in_item_i.func == srr_pkg::FUNC_TILE_WRITE);
  assign acc_render = accept && (in_item_i.func == srr_pkg::FUNC_RENDER);
  assign issue      = advance_i && active_q;

  assign row_y = {1'b0, in_item_i.attr0[7:0]} + {6'b0, in_item_i.sprite_row};
  assign pix_x = signed'({x0_q[8], x0_q}) +
                 signed'({{(10 - srr_pkg::PIX_IDX_W){1'b0}}, k_q});

  // Step to the next tile's row word, wrapping at the store depth
  assign tile_next_raw = {1'b0, tile_addr_q} + (TileAw + 1)'(8);
  assign tile_next     = (tile_next_raw >= (TileAw + 1)'(TileWords)) ?
                         TileAw'(tile_next_raw - (TileAw + 1)'(TileWords)) :
                         tile_next_raw[TileAw-1:0];

  // Hold sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
    end else begin
      if (acc_render) begin
        active_q <= 1'b1;
        k_q      <= '0;
      end else if (issue) begin
        if (k_q == srr_pkg::PIX_LAST) begin
          active_q <= 1'b0;
        end
        k_q <= k_q + 1'b1;
      end
    end
  end

  // Load the render context, advance the tile address per tile
  always_ff @(posedge clk_i) begin
    if (acc_render) begin
      x0_q        <= signed'(in_item_i.attr1[8:0]);
      y_q         <= row_y;
      visible_q   <= (in_item_i.attr0[9:8] != srr_pkg::MODE_HIDDEN) &&
                     (row_y < screen_height_i);
      bank_q      <= in_item_i.attr2[15:12];
      tile_addr_q <= wrap_addr({in_item_i.attr2[9:0], in_item_i.sprite_row});
    end else if (issue && (k_q[2:0] == srr_pkg::COL_LAST)) begin
      tile_addr_q <= tile_next;
    end
  end

  // Tile store: write on accept, read one word per issued pixel
  always_ff @(posedge clk_i) begin
    if (acc_tile) begin
      tile_mem[wrap_addr(in_item_i.address)] <= in_item_i.data;
    end
    if (issue) begin
      tile_rdata_q <= tile_mem[tile_addr_q];
    end
  end

  // Stage control toward shade
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_pal_wr_q <= 1'b0;
    end else if (advance_i) begin
      s1_valid_q  <= active_q;
      s1_pal_wr_q <= acc_pal;
    end
  end

  // Stage payload toward shade
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_q.valid    <= 1'b0;
      s1_q.pal_wr   <= 1'b0;
      s1_q.x        <= pix_x;
      s1_q.y        <= y_q;
      s1_q.visible  <= visible_q;
      s1_q.bank     <= bank_q;
      s1_q.col      <= k_q[2:0];
      s1_q.last     <= (k_q == srr_pkg::PIX_LAST);
      s1_q.pal_addr <= in_item_i.address[srr_pkg::PAL_AW-1:0];
      s1_q.pal_data <= in_item_i.data[14:0];
    end
  end

  always_comb begin
    stage_o        = s1_q;
    stage_o.valid  = s1_valid_q;
    stage_o.pal_wr = s1_pal_wr_q;
  end

  assign tile_word_o = tile_rdata_q;

endmodule

// ----- hdl/srr_shade.sv -----
// ----------------------------------------------------------------------------
// srr_shade: nibble select, clipping, palette lookup and result register
// Picks each pixel's nibble from its tile word, decides visibility, reads
// the palette and holds the finished pixel for the result channel.
// ----------------------------------------------------------------------------
module srr_shade (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  srr_pkg::stage_t stage_i,
  input  logic [31:0]     tile_word_i,
  input  logic [7:0]      width_minus_one_i,
  output logic            advance_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output srr_pkg::pixel_t out_item_o
);

  logic [14:0]       pal_mem [srr_pkg::PALETTE_ENTRIES];
  logic [14:0]       pal_rdata_q;

  logic              s2_valid_q;
  logic signed [9:0] s2_x_q;
  logic [8:0]        s2_y_q;
  logic              s2_on_q;
  logic              s2_last_q;

  logic [3:0]        nib;
  logic              on;

  // Move the whole pipeline whenever the result slot is free or taken
  assign advance_o = !s2_valid_q || out_ready_i;

  // Lowest nibble is the leftmost pixel
  assign nib = tile_word_i[{stage_i.col, 2'b00} +: 4];
  assign on  = stage_i.visible && (nib != 4'd0) && !stage_i.x[9] &&
               (stage_i.x[8:0] <= {1'b0, width_minus_one_i});

  // Palette: pending write and pixel read share the advancing edge
  always_ff @(posedge clk_i) begin
    if (advance_o && stage_i.pal_wr) begin
      pal_mem[stage_i.pal_addr] <= stage_i.pal_data;
    end
    if (advance_o && stage_i.valid) begin
      pal_rdata_q <= pal_mem[{stage_i.bank, nib}];
    end
  end

  // Hold result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance_o) begin
      s2_valid_q <= stage_i.valid;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    if (advance_o && stage_i.valid) begin
      s2_x_q    <= stage_i.x;
      s2_y_q    <= stage_i.y;
      s2_on_q   <= on;
      s2_last_q <= stage_i.last;
    end
  end

  assign out_valid_o             = s2_valid_q;
  assign out_item_o.pixel_x      = s2_x_q;
  assign out_item_o.pixel_y      = s2_y_q;
  assign out_item_o.color        = s2_on_q ? {1'b1, pal_rdata_q} : 16'd0;
  assign out_item_o.write_enable = s2_on_q;
  assign out_item_o.last         = s2_last_q;

endmodule

// ----- tb/sprite_row_checker.sv -----
// ----------------------------------------------------------------------------
// sprite_row_checker: pixel prediction and comparison for the row rasterizer
// Watches the item, pixel and register channels, keeps its own copy of the
// palette, tile store and screen limits, expands each render transaction into
// its 32 pixels and compares them field by field against the pixel channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_row_checker
  import srr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  item_t      in_item_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  pixel_t     out_item_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i,
  output int         pending_o,
  output int         fail_count_o,
  output int         pixels_o,
  output int         lit_o
);

  // Shadow stores and screen limits
  logic [14:0] pal_mem  [PALETTE_ENTRIES];
  logic [31:0] tile_mem [TILE_WORDS];
  logic [7:0]  width_m1;
  logic [8:0]  scr_height;

  pixel_t due_pixels[$];
  int     fails;
  int     pixels;
  int     lit;

  // Report a mismatching field, return 1 when it matches
  function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: pixel %0d %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, pixels, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expand one render transaction into the pixels it must produce
  function automatic void raster_row(item_t it);
    logic              hidden;
    logic [3:0]        bank;
    logic signed [9:0] x0;
    logic signed [9:0] x;
    logic [8:0]        y;
    logic              row_ok;
    logic [31:0]       word;
    logic [3:0]        nib;
    logic              on;
    pixel_t            px;
    hidden = (it.attr0[9:8] == MODE_HIDDEN);
    bank   = it.attr2[15:12];
    x0     = {it.attr1[8], it.attr1[8:0]};
    y      = {1'b0, it.attr0[7:0]} + 9'(it.sprite_row);
    row_ok = (y < scr_height);
    for (int t = 0; t < 4; t++) begin
      // tile word address wraps at the store depth
      word = tile_mem[((int'(it.attr2[9:0]) + t) * 8 + int'(it.sprite_row)) % TILE_WORDS];
      for (int c = 0; c < 8; c++) begin
        x   = x0 + 10'(t * 8 + c);
        nib = word[4*c +: 4];
        on  = !hidden && (nib != 4'd0) && row_ok && !x[9] && (x[8:0] <= {1'b0, width_m1});
        px.pixel_x      = x;
        px.pixel_y      = y;
        px.color        = on ? {1'b1, pal_mem[{bank, nib}]} : 16'h0000;
        px.write_enable = on;
        px.last         = (t == 3) && (c == 7);
        due_pixels.push_back(px);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t   want;
    bit [4:0] ok;
    if (!rst_ni) begin
      width_m1   = WIDTH_MINUS_ONE_RST;
      scr_height = SCREEN_HEIGHT_RST;
      due_pixels.delete();
      fails  = 0;
      pixels = 0;
      lit    = 0;
    end else begin
      // Compare a pixel transaction with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (due_pixels.size() == 0) begin
          $display("%0t: pixel transaction with nothing expected, actual x %0d y %0d color 0x%0h",
                   $time, out_item_i.pixel_x, out_item_i.pixel_y, out_item_i.color);
          fails++;
        end else begin
          want = due_pixels.pop_front();
          ok = {field_ok("pixel_x", 16'(want.pixel_x), 16'(out_item_i.pixel_x)),
                field_ok("pixel_y", 16'(want.pixel_y), 16'(out_item_i.pixel_y)),
                field_ok("color", want.color, out_item_i.color),
                field_ok("write_enable", 16'(want.write_enable), 16'(out_item_i.write_enable)),
                field_ok("last", 16'(want.last), 16'(out_item_i.last))};
          if (!(&ok)) fails++;
          if (want.write_enable) lit++;
          pixels++;
        end
      end

      // Track register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIDTH_MINUS_ONE: width_m1   = cfg_data_i[7:0];
          CFG_SCREEN_HEIGHT:   scr_height = cfg_data_i;
          default: ;
        endcase
      end

      // Apply an accepted item transaction
      if (in_valid_i && in_ready_i) begin
        case (in_item_i.func)
          FUNC_PAL_WRITE:  pal_mem[in_item_i.address[7:0]] = in_item_i.data[14:0];
          FUNC_TILE_WRITE: tile_mem[int'(in_item_i.address) % TILE_WORDS] = in_item_i.data;
          FUNC_RENDER:     raster_row(in_item_i);
          default: ;
        endcase
      end
    end
    pending_o    <= due_pixels.size();
    fail_count_o <= fails;
    pixels_o     <= pixels;
    lit_o        <= lit;
  end

endmodule

// ----- tb/sprite_row_rasterizer_core_tb.sv -----
// ----------------------------------------------------------------------------
// sprite_row_rasterizer_core_tb: stimulus and verdict for the row rasterizer
// Drives palette writes, tile writes, render rows and ignored items under
// random idling and a long output hold-off, reprograms the screen limits
// between phases, and reports the result of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_row_rasterizer_core_tb;
  import srr_pkg::*;

  localparam int         CLK_PERIOD   = 20;
  localparam int         RESET_CYCLES = 11;
  localparam int         QUIET_CYCLES = 8;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         RANDOM_ITEMS = 42;
  localparam int         PHASE_ITEMS  = 14;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  item_t      in_item;
  logic       out_valid;
  logic       out_ready;
  pixel_t     out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  int pending;
  int fail_count;
  int pixels;
  int lit;

  // Stimulus bookkeeping: which store entries hold data
  bit          pal_set  [PALETTE_ENTRIES];
  bit          tile_set [TILE_WORDS];
  logic [31:0] tile_data[TILE_WORDS];
  logic [9:0]  id_pool  [11];

  bit steady;
  bit rx_hold_req;
  int items_sent;
  int renders_sent;
  int ignored_sent;
  int settings_done;

  sprite_row_rasterizer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  sprite_row_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .fail_count_o(fail_count),
    .pixels_o    (pixels),
    .lit_o       (lit)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Hard stop on a hung run
  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  // Pixel receiver: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic int idle_gap();
    int gap = 0;
    if (steady) return 0;
    while ($urandom_range(99) < 33) gap++;
    if ($urandom_range(19) == 0) gap += $urandom_range(1, 40);
    return gap;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.func       = 2'($urandom);
    it.address    = 13'($urandom);
    it.data       = $urandom;
    it.attr0      = 16'($urandom);
    it.attr1      = 16'($urandom);
    it.attr2      = 16'($urandom);
    it.sprite_row = 3'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] tile_pattern();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom & $urandom;
    endcase
  endfunction

  // Offer one item transaction, idling first, and hold it until taken
  task automatic send_item(input item_t it);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (it.func == FUNC_UNUSED) ignored_sent++;
    else items_sent++;
    if (it.func == FUNC_RENDER) renders_sent++;
  endtask

  task automatic put_color(input logic [7:0] idx, input logic [4:0] upper,
                           input logic [31:0] value);
    item_t it;
    it = noise_item();
    it.func    = FUNC_PAL_WRITE;
    it.address = {upper, idx};
    it.data    = value;
    send_item(it);
    pal_set[idx] = 1'b1;
  endtask

  task automatic put_tile(input logic [12:0] addr, input logic [31:0] value);
    item_t it;
    it = noise_item();
    it.func    = FUNC_TILE_WRITE;
    it.address = addr;
    it.data    = value;
    send_item(it);
    tile_set[addr]  = 1'b1;
    tile_data[addr] = value;
  endtask

  // Fill any tile words and colors the row reads, then render it
  task automatic render_sprite(input logic [15:0] a0, input logic [15:0] a1,
                               input logic [15:0] a2, input logic [2:0] row);
    logic [12:0] taddr[4];
    logic [7:0]  pidx;
    item_t       it;
    for (int t = 0; t < 4; t++) begin
      taddr[t] = 13'(((int'(a2[9:0]) + t) * 8 + int'(row)) % TILE_WORDS);
      if (!tile_set[taddr[t]]) put_tile(taddr[t], tile_pattern());
    end
    for (int t = 0; t < 4; t++) begin
      for (int c = 0; c < 8; c++) begin
        pidx = {a2[15:12], tile_data[taddr[t]][4*c +: 4]};
        if (!pal_set[pidx]) put_color(pidx, 5'($urandom), $urandom);
      end
    end
    it = noise_item();
    it.func       = FUNC_RENDER;
    it.attr0      = a0;
    it.attr1      = a1;
    it.attr2      = a2;
    it.sprite_row = row;
    send_item(it);
  endtask

  // Draw from a few palette banks that together toggle every bank bit
  task automatic random_render();
    logic [15:0] a0;
    logic [15:0] a1;
    logic [15:0] a2;
    a0 = 16'($urandom);
    a1 = 16'($urandom);
    if ($urandom_range(1)) a1[8:0] = 9'($urandom_range(0, 255));
    a2 = 16'($urandom);
    a2[9:0] = id_pool[$urandom_range(10)];
    case ($urandom_range(3))
      0:       a2[15:12] = 4'h0;
      1:       a2[15:12] = 4'h5;
      2:       a2[15:12] = 4'hA;
      default: a2[15:12] = 4'hF;
    endcase
    render_sprite(a0, a1, a2, 3'($urandom));
  endtask

  // Drop valid and wait until every expected pixel has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic await_cfg();
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // Write both screen limits, with a write to a spare index in between
  task automatic program_screen(input logic [8:0] width_val, input logic [8:0] height_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WIDTH_MINUS_ONE;
    cfg_data  <= width_val;
    await_cfg();
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 9'($urandom);
    await_cfg();
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= height_val;
    await_cfg();
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  initial begin : stimulus
    item_t       it;
    int          base;
    int          next_phase;
    int          pick;
    logic [8:0]  width_val;
    logic [8:0]  height_val;
    logic [12:0] taddr;

    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_WIDTH_MINUS_ONE;
    cfg_data  <= '0;
    steady      = 1'b0;
    rx_hold_req = 1'b0;
    id_pool[0] = 10'd0;
    id_pool[1] = 10'd1023;
    id_pool[2] = 10'd1022;
    for (int i = 3; i < 11; i++) id_pool[i] = 10'($urandom);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: store extremes, tile address wrap, edges and clipping
    put_color(8'hFF, 5'h1F, 32'hFFFF_FFFF);
    put_color(8'h00, 5'h00, 32'h0000_0000);
    put_tile(13'h1FFF, 32'hFFFF_FFFF);
    put_tile(13'h0000, 32'h0000_0000);
    put_tile(13'h0007, 32'h1234_5678);
    render_sprite(16'h0000, 16'h0000, {4'hF, 2'b00, 10'd1023}, 3'd7);
    render_sprite(16'h0210, 16'h0100, 16'h0000, 3'd0);
    render_sprite(16'h00FF, 16'h00FF, 16'h5001, 3'd7);
    render_sprite(16'h0050, 16'h01E1, 16'hA000, 3'd0);
    render_sprite(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0);
    render_sprite(16'h0000, 16'h00E0, 16'h0402, 3'd3);
    it = '1;
    send_item(it);
    settle();

    // Widest screen: last column 255, all 256 rows
    program_screen(9'h0FF, 9'd256);
    render_sprite(16'h00FF, 16'h00F0, 16'hF010, 3'd0);
    render_sprite(16'h00F9, 16'h0000, 16'hF010, 3'd7);
    settle();

    // Narrowest screen: a single pixel, bit 8 of the width data ignored
    program_screen(9'h100, 9'd1);
    render_sprite(16'h0000, 16'h0000, 16'h5020, 3'd0);
    render_sprite(16'h0000, 16'h01FF, 16'h5020, 3'd1);
    settle();

    // Zero height clips every row
    program_screen(9'd100, 9'd0);
    render_sprite(16'h0010, 16'h0010, 16'hA030, 3'd2);
    settle();

    // Back-pressure: hold the pixel channel while rows keep coming
    program_screen(9'(WIDTH_MINUS_ONE_RST), SCREEN_HEIGHT_RST);
    rx_hold_req = 1'b1;
    repeat (4) random_render();
    settle();

    // Random part in phases of changing screen limits
    base       = items_sent;
    next_phase = PHASE_ITEMS;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (items_sent - base >= next_phase) begin
        settle();
        case ($urandom_range(9))
          0:       width_val = 9'd0;
          1:       width_val = 9'h0FF;
          default: width_val = 9'($urandom);
        endcase
        case ($urandom_range(9))
          0:       height_val = 9'd1;
          1:       height_val = 9'd256;
          default: height_val = 9'($urandom_range(1, 256));
        endcase
        program_screen(width_val, height_val);
        next_phase += PHASE_ITEMS;
      end
      steady = (items_sent - base >= PHASE_ITEMS) && (items_sent - base < 2 * PHASE_ITEMS);
      pick = $urandom_range(99);
      if (pick < 60) begin
        random_render();
      end else if (pick < 75) begin
        put_color(8'($urandom), 5'($urandom), $urandom);
      end else if (pick < 90) begin
        // rewrite a word the sprites use, or scatter one anywhere
        if ($urandom_range(1)) taddr = {id_pool[$urandom_range(10)], 3'($urandom)};
        else taddr = 13'($urandom);
        put_tile(taddr, tile_pattern());
      end else begin
        it = noise_item();
        it.func = FUNC_UNUSED;
        send_item(it);
      end
    end
    steady = 1'b0;
    settle();

    $display("Covered %0d transactions (%0d row renders, %0d ignored) over %0d screen settings,",
             items_sent, renders_sent, ignored_sent, settings_done);
    $display("comparing %0d pixels, %0d of them drawn, with one long output hold-off.",
             pixels, lit);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/srr_pkg.sv
hdl/srr_fetch.sv
hdl/srr_shade.sv
hdl/sprite_row_rasterizer_core.sv
tb/sprite_row_checker.sv
tb/sprite_row_rasterizer_core_tb.sv
